// File: hw/rtl/olsc_pkg.sv
// ----------------------------------------------------------------------------
// olsc_pkg: shared types and constants for open-loop sine commutation
// Holds the configuration record, register indexes, the back-end sequencer
// states and the interpolation sine table, which is built at elaboration.
// ----------------------------------------------------------------------------
package olsc_pkg;

  // Sine table geometry; the size must be a power of two
  localparam int SineTableSize = 512;
  localparam int SineAddrW     = $clog2(SineTableSize);
  localparam int SineTabW      = 16;
  localparam int AngleW        = 15;
  localparam int CompareW      = 7;
  localparam int PwmPeriod     = 127;

  // One third of a turn in 15-bit angle units
  localparam int ThirdTurn     = 'h2AAB;
  localparam int PhaseWrapLim  = 'h7FFF;
  localparam longint PiQ30     = 64'sd3373259426;

  // Table position modulo one turn, counted in quarter steps
  localparam longint SineTurnMask = 4 * longint'(SineTableSize) - 1;

  // Handoff queue between the front and back parts
  localparam int QueueDepth    = 2;
  localparam int QueuePtrW     = $clog2(QueueDepth);

  // Configuration port
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 32;
  localparam logic [CfgIdxW-1:0] CfgRampLimit     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRampIncrement = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStepLimit     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDutyAmplitude = 2'd3;

  localparam logic [9:0]  RampLimitReset     = 10'd600;
  localparam logic [23:0] RampIncrementReset = 24'd683565;

  // Phase slots of one result
  localparam logic [1:0] PhaseFirst = 2'd0;
  localparam logic [1:0] PhaseLast  = 2'd2;

  typedef struct packed {
    logic [9:0]         ramp_limit;
    logic [23:0]        ramp_increment;
    logic signed [31:0] step_limit;
    logic [7:0]         duty_amplitude;
  } cfg_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkLookup,
    BkMul,
    BkSum,
    BkScale,
    BkStore,
    BkOut
  } back_state_e;

  typedef logic signed [SineTabW-1:0] sine_tab_t [SineTableSize+1];

  // Taylor series of sin(x), x and result in Q30, 0 <= x <= pi/2
  function automatic longint sin_q30(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 210;
    sum  = sum - term;
    return sum;
  endfunction

  function automatic sine_tab_t gen_sine_tab();
    sine_tab_t tab;
    longint    u;
    longint    r;
    longint    v;
    logic      neg;
    for (int k = 0; k <= SineTableSize; k++) begin
      u   = (4 * longint'(k)) & SineTurnMask;
      neg = 1'b0;
      if (u <= SineTableSize) begin
        r = u;
      end else if (u <= 2 * SineTableSize) begin
        r = 2 * SineTableSize - u;
      end else if (u <= 3 * SineTableSize) begin
        r   = u - 2 * SineTableSize;
        neg = 1'b1;
      end else begin
        r   = 4 * SineTableSize - u;
        neg = 1'b1;
      end
      // angle r * pi / (2 * size), the product is never negative
      v = (sin_q30((r * PiQ30) >>> (SineAddrW + 1)) + (64'sd1 <<< 14)) >>> 15;
      if (v > 32767) v = 32767;
      if (v < 0) v = 0;
      tab[k] = neg ? SineTabW'(-v) : SineTabW'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = gen_sine_tab();

endpackage

// File: hw/rtl/olsc_front.sv
// ----------------------------------------------------------------------------
// olsc_front: tick intake, speed ramp and phase accumulator
// Accepts ticks, updates the ramp counter and angle step in the accept cycle,
// advances the phase accumulator in the next cycle and queues the new angle.
// ----------------------------------------------------------------------------
module olsc_front import olsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              tick_i,
  output logic              push_o,
  output logic [AngleW-1:0] push_angle_o,
  input  logic              q_full_i
);

  logic [9:0]         ramp_count_q, ramp_count_d;
  logic signed [31:0] angle_step_q, angle_step_d;
  logic [31:0]        phase_acc_q, phase_acc_d;
  logic               busy_q, busy_d;
  logic               accept;
  logic signed [32:0] ramp_sum;

  assign in_stall_o = busy_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    ramp_count_d = ramp_count_q;
    angle_step_d = angle_step_q;
    busy_d       = 1'b0;
    ramp_sum     = {angle_step_q[31], angle_step_q} + $signed({9'b0, cfg_i.ramp_increment});
    if (accept && tick_i) begin
      busy_d = 1'b1;
      if (ramp_count_q > cfg_i.ramp_limit) begin
        ramp_count_d = '0;
        // clamp the grown step from above
        if (ramp_sum > $signed({cfg_i.step_limit[31], cfg_i.step_limit})) begin
          angle_step_d = cfg_i.step_limit;
        end else begin
          angle_step_d = ramp_sum[31:0];
        end
      end else begin
        ramp_count_d = ramp_count_q + 10'd1;
      end
    end
  end

  // advance the accumulator the cycle after the step settles
  always_comb begin
    phase_acc_d = phase_acc_q;
    if (busy_q && (cfg_i.step_limit != '0)) begin
      phase_acc_d = phase_acc_q + angle_step_q;
    end
  end

  assign push_o       = busy_q;
  assign push_angle_o = phase_acc_d[31 -: AngleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_count_q <= '0;
      angle_step_q <= '0;
      phase_acc_q  <= '0;
      busy_q       <= 1'b0;
    end else begin
      ramp_count_q <= ramp_count_d;
      angle_step_q <= angle_step_d;
      phase_acc_q  <= phase_acc_d;
      busy_q       <= busy_d;
    end
  end

endmodule

// File: hw/rtl/olsc_queue.sv
// ----------------------------------------------------------------------------
// olsc_queue: short angle queue between front and back
// Small circular buffer; the front pushes angles, the back pops them.
// ----------------------------------------------------------------------------
module olsc_queue import olsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [AngleW-1:0] push_angle_i,
  input  logic              pop_i,
  output logic [AngleW-1:0] pop_angle_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [AngleW-1:0]    mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;

  assign full_o      = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o     = (count_q == '0);
  assign pop_angle_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hw/rtl/olsc_back.sv
// ----------------------------------------------------------------------------
// olsc_back: per-phase sine lookup, scaling and result register
// Runs the three phases of one angle through a shared sine ROM and multiply
// path, phase by phase, and holds the finished result for the sink.
// ----------------------------------------------------------------------------
module olsc_back import olsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_empty_i,
  input  logic [AngleW-1:0]   q_angle_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CompareW-1:0] compare_a_o,
  output logic [CompareW-1:0] compare_b_o,
  output logic [CompareW-1:0] compare_c_o,
  output logic                side_a_o,
  output logic                side_b_o,
  output logic                side_c_o,
  output logic [AngleW-1:0]   electrical_angle_o
);

  back_state_e state_q, state_d;

  logic [1:0]                 phase_q;
  logic [AngleW-1:0]          angle_a_q;
  logic signed [AngleW+1:0]   cur_q;
  logic signed [SineTabW-1:0] tab_lo_q, tab_hi_q;
  logic [AngleW-1:0]          frac_q;
  logic signed [31:0]         prod_lo_q;
  logic signed [31:0]         prod_hi_q;
  logic                       neg_q;
  logic [15:0]                mag_q;
  logic [23:0]                scaled_q;
  logic [CompareW-1:0]        cmp_q [3];
  logic                       side_q [3];
  logic                       out_valid_q;
  logic                       load_out;

  logic [SineAddrW-1:0]       tab_idx;
  logic [AngleW-1:0]          frac;
  logic [AngleW-1:0]          cur_angle;
  logic signed [16:0]         half_sum;
  logic [16:0]                half_mag;
  logic [24:0]                depth_sum;
  logic [9:0]                 depth;
  logic [CompareW-1:0]        compare;

  // step one third of a turn, folding back by two thirds near the top
  function automatic logic signed [AngleW+1:0] next_phase(logic signed [AngleW+1:0] a);
    logic signed [AngleW+2:0] sum;
    sum = {a[AngleW+1], a} + (AngleW+3)'(ThirdTurn);
    if (sum >= (AngleW+3)'(PhaseWrapLim)) begin
      return a - (AngleW+2)'(2 * ThirdTurn);
    end
    return sum[AngleW+1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:   if (!q_empty_i) state_d = BkLookup;
      BkLookup: state_d = BkMul;
      BkMul:    state_d = BkSum;
      BkSum:    state_d = BkScale;
      BkScale:  state_d = BkStore;
      BkStore:  state_d = (phase_q == PhaseLast) ? BkOut : BkLookup;
      BkOut:    if (!out_valid_q || !out_stall_i) state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BkIdle:  pop_o    = !q_empty_i;
      BkOut:   load_out = !out_valid_q || !out_stall_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // table address and interpolation fraction of the current phase
  assign cur_angle = cur_q[AngleW-1:0];
  assign tab_idx   = cur_angle[AngleW-1 -: SineAddrW];
  assign frac      = AngleW'(cur_angle << SineAddrW);

  // sine ROM, registered read of two neighboring entries
  always_ff @(posedge clk_i) begin
    tab_lo_q <= SineTab[tab_idx];
    tab_hi_q <= SineTab[{1'b0, tab_idx} + (SineAddrW+1)'(1)];
    frac_q   <= frac;
  end

  assign half_sum  = 17'(prod_lo_q >>> 16) + 17'(prod_hi_q >>> 16);
  assign half_mag  = half_sum[16] ? 17'(-half_sum) : 17'(half_sum);
  assign depth_sum = {1'b0, scaled_q} + 25'd32767;
  assign depth     = depth_sum[24:15];
  assign compare   = (depth < 10'(PwmPeriod)) ? CompareW'(10'(PwmPeriod) - depth) : '0;

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          angle_a_q <= q_angle_i;
          cur_q     <= {2'b00, q_angle_i};
        end
      end
      BkMul: begin
        prod_lo_q <= 32'($signed({1'b0, 16'(17'd32768 - {2'b00, frac_q})}) * tab_lo_q);
        prod_hi_q <= 32'($signed({1'b0, frac_q}) * tab_hi_q);
      end
      BkSum: begin
        neg_q <= half_sum[16];
        mag_q <= {half_mag[14:0], 1'b0};
      end
      BkScale: begin
        scaled_q <= cfg_i.duty_amplitude * mag_q;
      end
      BkStore: begin
        cmp_q[phase_q]  <= compare;
        side_q[phase_q] <= neg_q;
        cur_q           <= next_phase(cur_q);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      compare_a_o        <= cmp_q[0];
      compare_b_o        <= cmp_q[1];
      compare_c_o        <= cmp_q[2];
      side_a_o           <= side_q[0];
      side_b_o           <= side_q[1];
      side_c_o           <= side_q[2];
      electrical_angle_o <= angle_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      phase_q     <= PhaseFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        phase_q <= PhaseFirst;
      end else if (state_q == BkStore) begin
        phase_q <= phase_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/open_loop_sine_commutation.sv
// ----------------------------------------------------------------------------
// open_loop_sine_commutation: open-loop three-phase sine PWM commutation
// Each tick is one PWM period. A speed ramp drives a phase accumulator and
// three 120-degree phases are turned into PWM compare values and side flags.
// Usage:
//   Input channel (in_valid_i / in_stall_o / tick_i): one item per PWM period.
//   A tick of 1 advances the ramp and the angle and yields one result; a tick
//   of 0 is taken and dropped without a result.
//   Output channel (out_valid_o / out_stall_i): compare and side per phase and
//   the phase A electrical angle.
//   Configuration (cfg_we_i / cfg_index_i / cfg_wdata_i): write while idle.
//   The back end works the three phases in turn on the shared sine ROM and
//   multiply path; the front registers the ramp and step, then advances the
//   accumulator and pushes the angle, holding in_stall_o high meanwhile.
//   A two-entry queue lets the front take ticks while the back works. While
//   the receiver stalls, the back waits with its next result and the queue
//   fills, after which in_stall_o is raised.
//   Reset: ramp counter, angle step and accumulator clear, registers take
//   their defaults, no result is pending.
// ----------------------------------------------------------------------------
module open_loop_sine_commutation import olsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                tick_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CompareW-1:0] compare_a_o,
  output logic [CompareW-1:0] compare_b_o,
  output logic [CompareW-1:0] compare_c_o,
  output logic                side_a_o,
  output logic                side_b_o,
  output logic                side_c_o,
  output logic [AngleW-1:0]   electrical_angle_o
);

  cfg_t              cfg_q;
  logic              push;
  logic [AngleW-1:0] push_angle;
  logic              pop;
  logic [AngleW-1:0] pop_angle;
  logic              q_full;
  logic              q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_limit     <= RampLimitReset;
      cfg_q.ramp_increment <= RampIncrementReset;
      cfg_q.step_limit     <= '0;
      cfg_q.duty_amplitude <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRampLimit:     cfg_q.ramp_limit     <= cfg_wdata_i[9:0];
        CfgRampIncrement: cfg_q.ramp_increment <= cfg_wdata_i[23:0];
        CfgStepLimit:     cfg_q.step_limit     <= $signed(cfg_wdata_i);
        CfgDutyAmplitude: cfg_q.duty_amplitude <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  olsc_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .tick_i,
    .push_o       (push),
    .push_angle_o (push_angle),
    .q_full_i     (q_full)
  );

  olsc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_angle_i (push_angle),
    .pop_i        (pop),
    .pop_angle_o  (pop_angle),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  olsc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_angle_i    (pop_angle),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .compare_a_o,
    .compare_b_o,
    .compare_c_o,
    .side_a_o,
    .side_b_o,
    .side_c_o,
    .electrical_angle_o
  );

endmodule

// File: sim/olsc_pwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olsc_pwm_checker: result predictor and scoreboard for the sine commutation
// Follows configuration writes and both item channels. It keeps its own ramp
// counter, angle step and phase accumulator, predicts the compare values, side
// flags and angle of every accepted tick, and checks each result in order.
// ----------------------------------------------------------------------------
module olsc_pwm_checker import olsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic                tick_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [CompareW-1:0] compare_a_o,
  input  logic [CompareW-1:0] compare_b_o,
  input  logic [CompareW-1:0] compare_c_o,
  input  logic                side_a_o,
  input  logic                side_b_o,
  input  logic                side_c_o,
  input  logic [AngleW-1:0]   electrical_angle_o,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int     LutSize      = 512;
  localparam longint PiTimes2p30  = 64'sd3373259426;
  localparam int     OneThird     = 10923;
  localparam int     WrapLimit    = 32767;
  localparam int     Period       = 127;
  localparam int     RampLimDflt  = 600;
  localparam int     RampIncDflt  = 683565;
  localparam int     MaxReports   = 10;

  typedef struct packed {
    logic [CompareW-1:0] cmp_a;
    logic [CompareW-1:0] cmp_b;
    logic [CompareW-1:0] cmp_c;
    logic                side_a;
    logic                side_b;
    logic                side_c;
    logic [AngleW-1:0]   angle;
  } pwm_result_t;

  int          sine_lut [0:LutSize];
  logic [9:0]  ramp_lim;
  logic [23:0] ramp_inc;
  int          step_lim;
  logic [7:0]  duty;
  logic [9:0]  ramp_cnt;
  int          angle_inc;
  logic [31:0] accum;
  pwm_result_t expected_pwm_q [$];

  // Q30 Taylor series of sin(x), 0 <= x <= pi/2
  function automatic longint taylor_sin_q30(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
      sum  = (n % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  initial begin : build_lut
    longint u;
    longint r;
    longint v;
    bit     neg;
    for (int k = 0; k <= LutSize; k++) begin
      u   = (4 * longint'(k)) % (4 * LutSize);
      neg = 1'b0;
      if (u <= LutSize) begin
        r = u;
      end else if (u <= 2 * LutSize) begin
        r = 2 * LutSize - u;
      end else if (u <= 3 * LutSize) begin
        r   = u - 2 * LutSize;
        neg = 1'b1;
      end else begin
        r   = 4 * LutSize - u;
        neg = 1'b1;
      end
      v = (taylor_sin_q30((r * PiTimes2p30) / (2 * LutSize)) + 16384) >>> 15;
      if (v > 32767) v = 32767;
      if (v < 0) v = 0;
      sine_lut[k] = neg ? -int'(v) : int'(v);
    end
  end

  // Interpolated Q15 sine of a 15-bit angle
  function automatic int sine_at(int ang);
    longint p;
    longint f;
    longint t;
    int     idx;
    p   = longint'(ang[14:0]) * LutSize;
    idx = int'(p >> 15);
    f   = p & 64'h7FFF;
    if (idx >= LutSize) idx = LutSize - 1;
    t = ((32768 - f) * sine_lut[idx]) >>> 16;
    t = (t * 65536 + f * sine_lut[idx + 1]) >>> 16;
    return int'(t * 2);
  endfunction

  function automatic int next_phase(int a);
    return (a + OneThird >= WrapLimit) ? a - 2 * OneThird : a + OneThird;
  endfunction

  function automatic void phase_drive(input int ang, output logic [CompareW-1:0] cmp,
                                      output logic side);
    int     s;
    longint mag;
    longint depth;
    s     = sine_at(ang);
    mag   = (s < 0) ? -longint'(s) : longint'(s);
    depth = (longint'(duty) * mag + 32767) >> 15;
    cmp   = (Period > depth) ? CompareW'(Period - depth) : '0;
    side  = (s < 0);
  endfunction

  // Advance ramp and accumulator by one tick and return the predicted result
  function automatic pwm_result_t advance_tick();
    longint      sum;
    int          a;
    int          b;
    int          c;
    pwm_result_t r;
    if (ramp_cnt > ramp_lim) begin
      sum      = longint'(angle_inc) + longint'(ramp_inc);
      ramp_cnt = '0;
      if (sum > longint'(step_lim)) sum = step_lim;
      angle_inc = int'(sum);
    end else begin
      ramp_cnt = ramp_cnt + 10'd1;
    end
    if (step_lim != 0) accum = accum + angle_inc;
    a = int'(accum[31:17]);
    b = next_phase(a);
    c = next_phase(b);
    phase_drive(a, r.cmp_a, r.side_a);
    phase_drive(b, r.cmp_b, r.side_b);
    phase_drive(c, r.cmp_c, r.side_c);
    r.angle = AngleW'(a);
    return r;
  endfunction

  function automatic void restore_defaults();
    ramp_lim  = 10'(RampLimDflt);
    ramp_inc  = 24'(RampIncDflt);
    step_lim  = 0;
    duty      = '0;
    ramp_cnt  = '0;
    angle_inc = 0;
    accum     = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pwm_result_t got;
    pwm_result_t want;
    if (!rst_ni) begin
      restore_defaults();
      expected_pwm_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgRampLimit:     ramp_lim = cfg_wdata_i[9:0];
          CfgRampIncrement: ramp_inc = cfg_wdata_i[23:0];
          CfgStepLimit:     step_lim = $signed(cfg_wdata_i);
          CfgDutyAmplitude: duty     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o && tick_i) expected_pwm_q.push_back(advance_tick());
      if (out_valid_o && !out_stall_i) begin
        got = {compare_a_o, compare_b_o, compare_c_o, side_a_o, side_b_o, side_c_o,
               electrical_angle_o};
        if (expected_pwm_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display("%0t: unexpected result cmp %0d %0d %0d side %b%b%b angle %0d",
                     $time, got.cmp_a, got.cmp_b, got.cmp_c, got.side_a, got.side_b,
                     got.side_c, got.angle);
        end else begin
          want = expected_pwm_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $display({"%0t: mismatch, expected cmp %0d %0d %0d side %b%b%b angle %0d,",
                        " got cmp %0d %0d %0d side %b%b%b angle %0d"},
                       $time, want.cmp_a, want.cmp_b, want.cmp_c, want.side_a,
                       want.side_b, want.side_c, want.angle, got.cmp_a, got.cmp_b,
                       got.cmp_c, got.side_a, got.side_b, got.side_c, got.angle);
          end
        end
      end
      pending_o <= expected_pwm_q.size();
    end
  end

endmodule

// File: sim/tb_open_loop_sine_commutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_loop_sine_commutation: testbench for open-loop sine commutation
// Drives directed and random tick items through several register settings,
// with random idling on both channels, a long output hold-off and a pause at
// every setting change. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_open_loop_sine_commutation;
  import olsc_pkg::*;

  localparam int LongHold     = 300;
  localparam int WatchLimit   = 2000;
  localparam int SettleCycles = 30;
  localparam int NumPhases    = 10;
  localparam int PhaseTicks   = 55;
  localparam int WrapPhase    = 4;
  localparam int WrapTicks    = 1030;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                tick      = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [CompareW-1:0] compare_a;
  logic [CompareW-1:0] compare_b;
  logic [CompareW-1:0] compare_c;
  logic                side_a;
  logic                side_b;
  logic                side_c;
  logic [AngleW-1:0]   angle;

  int fail_count;
  int pending;
  int send_pct    = 0;
  int recv_pct    = 0;
  int ticks_sent  = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  open_loop_sine_commutation dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .tick_i             (tick),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .compare_a_o        (compare_a),
    .compare_b_o        (compare_b),
    .compare_c_o        (compare_c),
    .side_a_o           (side_a),
    .side_b_o           (side_b),
    .side_c_o           (side_c),
    .electrical_angle_o (angle)
  );

  olsc_pwm_checker u_pwm_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .tick_i             (tick),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .compare_a_o        (compare_a),
    .compare_b_o        (compare_b),
    .compare_c_o        (compare_c),
    .side_a_o           (side_a),
    .side_b_o           (side_b),
    .side_c_o           (side_c),
    .electrical_angle_o (angle),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [9:0] rl, input logic [23:0] ri,
                             input logic [31:0] sl, input logic [7:0] da);
    write_reg(CfgRampLimit, {22'd0, rl});
    write_reg(CfgRampIncrement, {8'd0, ri});
    write_reg(CfgStepLimit, sl);
    write_reg(CfgDutyAmplitude, {24'd0, da});
    cfg_we <= 1'b0;
  endtask

  // Drain every expected result, then idle for SettleCycles
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_tick(input logic t);
    if (ticks_sent < 600) begin
      send_pct = 10;
      recv_pct <= 78;
    end else if (ticks_sent < 1200) begin
      send_pct = 78;
      recv_pct <= 10;
    end else begin
      send_pct = 0;
      recv_pct <= 0;
    end
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    tick     <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (t) ticks_sent++;
  endtask

  // Send n live ticks with dropped tick-0 items mixed in
  task automatic push_run(input int n);
    int live;
    live = 0;
    while (live < n) begin
      if ($urandom_range(9) == 0) begin
        push_tick(1'b0);
      end else begin
        push_tick(1'b1);
        live++;
      end
    end
  endtask

  task automatic random_config(input bit full_scale);
    logic [9:0]  rl;
    logic [23:0] ri;
    logic [31:0] sl;
    logic [7:0]  da;
    case ($urandom_range(7))
      0:       rl = 10'd0;
      1:       rl = 10'($urandom_range(0, 1023));
      default: rl = 10'($urandom_range(1, 6));
    endcase
    if (full_scale) rl = 10'd1023;
    case ($urandom_range(5))
      0:       ri = 24'd0;
      1:       ri = 24'hFFFFFF;
      default: ri = 24'($urandom());
    endcase
    case ($urandom_range(7))
      0:       sl = 32'd0;
      1:       sl = 32'h7FFFFFFF;
      2:       sl = 32'h80000000;
      3:       sl = 32'(0 - $urandom_range(1, 32'h00FFFFFF));
      default: sl = $urandom();
    endcase
    case ($urandom_range(5))
      0:       da = 8'd0;
      1:       da = 8'd255;
      default: da = 8'($urandom_range(0, 255));
    endcase
    load_config(rl, ri, sl, da);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no rotation, zero duty
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    settle();
    // Fastest ramp, widest positive limit, saturated compare
    load_config(10'd0, 24'hFFFFFF, 32'h7FFFFFFF, 8'd255);
    repeat (8) push_tick(1'b1);
    settle();
    // Most negative limit: every ramp event snaps the step to it
    load_config(10'd1, 24'd0, 32'h80000000, 8'd128);
    repeat (6) push_tick(1'b1);
    settle();
    // Step clamped at a small positive limit, minimal duty
    load_config(10'd2, 24'h123456, 32'd3000000, 8'd1);
    repeat (8) push_tick(1'b1);
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      random_config(ph == WrapPhase);
      if (ph == 1) hold_req <= 1'b1;
      push_run((ph == WrapPhase) ? WrapTicks : PhaseTicks);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
